FILE: hdl/bucketed_stack_map_core_assert.svh
// Assertion macros shared by the bucketed stack map RTL.
// Each one is empty when SYNTHESIS is defined.
`ifndef BUCKETED_STACK_MAP_CORE_ASSERT_SVH
`define BUCKETED_STACK_MAP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsm: same-cycle check failed");
`define BSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsm: next-cycle check failed");
`else
`define BSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/bsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    localparam int BUCKETS    = 16;
    localparam int POOL_NODES = 64;
    localparam int VALUE_BITS = 32;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 8;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int IN_W    = ((KEY_W + DATA_W + 7) / 8) * 8;

    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NODE_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int CNT_W   = $clog2(POOL_NODES + 1);
    localparam int STORE_W = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;

    localparam logic [DATA_W-1:0] MINUS_ONE = DATA_W'({STORE_W{1'b1}});

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SPARE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_KEY = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/bsm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bsm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire bsm_pkg::t_sts i_sts,
    output bsm_pkg::t_ctl      o_ctl
);

    import bsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   commit;
    logic   load;

    assign commit     = (r_state == S_FINISH) && i_sts.out_free;
    // a new beat may enter in the same cycle the previous one commits
    assign o_s_tready = (r_state == S_IDLE) || commit;
    assign load       = o_s_tready && i_s_tvalid;

    assign o_ctl.load   = load;
    assign o_ctl.rd_en  = (r_state == S_LOOKUP);
    assign o_ctl.commit = commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (commit) begin
                    n_state = load ? S_LOOKUP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bsm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bsm_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bsm_pkg::t_ctl                 i_ctl,
    output bsm_pkg::t_sts                      o_sts,
    input  wire logic [bsm_pkg::IN_W-1:0]      i_s_tdata,
    input  wire logic [bsm_pkg::CMD_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [bsm_pkg::DATA_W-1:0]    o_m_tdata,
    output logic      [bsm_pkg::STAT_W-1:0]    o_m_tuser
);

    import bsm_pkg::*;

    // captured beat
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [STORE_W-1:0] r_value;

    // bucket heads in flops, each with a valid bit
    logic [NODE_W-1:0]  r_head     [BUCKETS];
    logic [BUCKETS-1:0] r_head_vld;

    logic [NODE_W-1:0]  r_free_head;
    logic               r_free_vld;
    logic [CNT_W-1:0]   r_fresh;

    logic               r_out_vld;
    logic [DATA_W-1:0]  r_out_data;
    t_status            r_out_stat;

    logic [BKT_W-1:0]   bkt;
    logic               bad_key;
    logic               hv;
    logic [NODE_W-1:0]  hn;

    logic [NODE_W-1:0]  rd_addr;
    logic [STORE_W-1:0] val_rdata;
    logic [NODE_W:0]    link_rdata;

    logic               we_node;
    logic               we_link;
    logic [NODE_W-1:0]  waddr;
    logic [NODE_W:0]    link_wdata;
    logic               head_we;
    logic [NODE_W-1:0]  head_new;
    logic               head_new_vld;
    logic               free_we;
    logic [NODE_W-1:0]  free_new;
    logic               free_new_vld;
    logic               fresh_inc;
    logic [STORE_W-1:0] res_data;
    t_status            res_stat;

    assign bkt     = r_key[BKT_W-1:0];
    assign bad_key = {1'b0, r_key} >= (KEY_W + 1)'(BUCKETS);
    assign hv      = r_head_vld[bkt];
    assign hn      = r_head[bkt];

    // a put reads the next free link, get/remove read the head node
    assign rd_addr = (r_cmd == CMD_PUT) ? r_free_head : hn;

    assign o_sts.out_free = !r_out_vld || i_m_tready;

    always_comb begin
        we_node      = 1'b0;
        we_link      = 1'b0;
        waddr        = hn;
        link_wdata   = {hv, hn};
        head_we      = 1'b0;
        head_new     = hn;
        head_new_vld = hv;
        free_we      = 1'b0;
        free_new     = r_free_head;
        free_new_vld = r_free_vld;
        fresh_inc    = 1'b0;
        res_data     = {STORE_W{1'b1}};
        res_stat     = ST_OK;
        if (bad_key) begin
            res_stat = ST_BAD_KEY;
        end else begin
            unique case (r_cmd)
                CMD_PUT: begin
                    if (r_free_vld) begin
                        waddr        = r_free_head;
                        free_we      = 1'b1;
                        free_new     = link_rdata[NODE_W-1:0];
                        free_new_vld = link_rdata[NODE_W];
                    end else if (r_fresh < CNT_W'(POOL_NODES)) begin
                        waddr     = r_fresh[NODE_W-1:0];
                        fresh_inc = 1'b1;
                    end else begin
                        res_stat = ST_FULL;
                    end
                    if (res_stat == ST_OK) begin
                        we_node      = 1'b1;
                        we_link      = 1'b1;
                        link_wdata   = {hv, hn};
                        head_we      = 1'b1;
                        head_new     = waddr;
                        head_new_vld = 1'b1;
                        res_data     = '0;
                    end
                end
                CMD_REMOVE: begin
                    if (!hv) begin
                        res_stat = ST_EMPTY;
                    end else begin
                        res_data     = val_rdata;
                        head_we      = 1'b1;
                        head_new     = link_rdata[NODE_W-1:0];
                        head_new_vld = link_rdata[NODE_W];
                        // popped node goes on top of the free list
                        we_link      = 1'b1;
                        waddr        = hn;
                        link_wdata   = {r_free_vld, r_free_head};
                        free_we      = 1'b1;
                        free_new     = hn;
                        free_new_vld = 1'b1;
                    end
                end
                CMD_GET, CMD_SPARE: begin
                    if (!hv) begin
                        res_stat = ST_EMPTY;
                    end else begin
                        res_data = val_rdata;
                    end
                end
                default: begin
                    res_stat = ST_EMPTY;
                end
            endcase
        end
    end

    bsm_ram #(
        .WIDTH (STORE_W),
        .DEPTH (POOL_NODES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.commit && we_node),
        .i_waddr (waddr),
        .i_wdata (r_value),
        .i_re    (i_ctl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    bsm_ram #(
        .WIDTH (NODE_W + 1),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.commit && we_link),
        .i_waddr (waddr),
        .i_wdata (link_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= t_cmd'(i_s_tuser);
            r_key   <= i_s_tdata[KEY_W-1:0];
            r_value <= i_s_tdata[KEY_W +: STORE_W];
        end
        if (i_ctl.commit && head_we) begin
            r_head[bkt] <= head_new;
        end
        if (i_ctl.commit) begin
            r_out_data <= DATA_W'(res_data);
            r_out_stat <= res_stat;
        end
        if (i_ctl.commit && free_we) begin
            r_free_head <= free_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
            r_free_vld <= 1'b0;
            r_fresh    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_ctl.commit && head_we) begin
                r_head_vld[bkt] <= head_new_vld;
            end
            if (i_ctl.commit && free_we) begin
                r_free_vld <= free_new_vld;
            end
            if (i_ctl.commit && fresh_inc) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (i_ctl.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_stat;

endmodule

`default_nettype wire

FILE: hdl/bucketed_stack_map_core.sv
// Flow: an accepted beat is registered, S_LOOKUP issues the node memory read, and
// S_FINISH commits once the output register is free, which raises o_m_tvalid.
// A new beat may be accepted in the same cycle that the previous one commits.
// Reset: synchronous, active low; clears bucket valid bits, free list, fresh count and
// output valid. Node memories are not cleared, so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "bucketed_stack_map_core_assert.svh"

module bucketed_stack_map_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] key, [39:8] value
    input  wire logic [bsm_pkg::IN_W-1:0]      i_s_tdata,
    // [1:0] command
    input  wire logic [bsm_pkg::CMD_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [31:0] result_value
    output logic      [bsm_pkg::DATA_W-1:0]    o_m_tdata,
    // [1:0] status
    output logic      [bsm_pkg::STAT_W-1:0]    o_m_tuser
);

    import bsm_pkg::*;

    t_ctl ctl;
    t_sts sts;

    bsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    bsm_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    `BSM_ASSERT_NXT(a_lookup_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `BSM_ASSERT_IMP(a_commit_slot_free, i_clk, i_rst_n, ctl.commit, !o_m_tvalid || i_m_tready)
    `BSM_ASSERT_NXT(a_commit_shows, i_clk, i_rst_n, ctl.commit, o_m_tvalid)
    `BSM_ASSERT_IMP(a_fail_minus_one, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != ST_OK), o_m_tdata == MINUS_ONE)

endmodule

`default_nettype wire
